### rtl/core/hamming74_stream_decoder_unit_macros.svh
// Assertion macros shared by the Hamming(7,4) stream decoder modules.
`ifndef HAMMING74_STREAM_DECODER_UNIT_MACROS_SVH
`define HAMMING74_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsd assertion failed");

`endif

### rtl/core/hsd_pkg.sv
// Shared types, constants and the codeword correction function of the decoder.
package hsd_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic [1:0] nibble_count;
        logic       end_of_message;
    } hsd_result_t;

    // One queue entry: the results caused by one input beat.
    typedef struct packed {
        hsd_result_t res0;
        hsd_result_t res1;
        logic        two;
    } hsd_entry_t;

    // Codeword layout, msb first: p1 p2 d1 p3 d2 d3 d4.
    function automatic logic [3:0] hsd_decode(input logic [6:0] w);
        logic [2:0] syn;
        logic [6:0] flip;
        logic [6:0] fixed;
        syn[0] = w[6] ^ w[4] ^ w[2] ^ w[0];
        syn[1] = w[5] ^ w[4] ^ w[1] ^ w[0];
        syn[2] = w[3] ^ w[2] ^ w[1] ^ w[0];
        flip   = (syn != 3'd0) ? (7'd1 << (3'd7 - syn)) : 7'd0;
        fixed  = w ^ flip;
        return {fixed[4], fixed[2], fixed[1], fixed[0]};
    endfunction

endpackage

### rtl/core/hsd_if.sv
// Valid/ready stream interfaces for coded input beats and decoded result beats.
interface hsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       is_last;

    modport source (output valid, output coded_byte, output is_last, input ready);
    modport sink   (input valid, input coded_byte, input is_last, output ready);
endinterface

interface hsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic [1:0] nibble_count;
    logic       end_of_message;

    modport source (output valid, output decoded_byte, output nibble_count,
                    output end_of_message, input ready);
    modport sink   (input valid, input decoded_byte, input nibble_count,
                    input end_of_message, output ready);
endinterface

### rtl/core/hamming74_stream_decoder_unit.sv
// Top level of the Hamming(7,4) stream decoder: front end, result queue, back end.
// A result beat is offered from the queue entry that its coded beat pushed.
// Throughput: one coded beat per cycle while the result queue has room; the back
// end sends one result beat per cycle while the sink is ready, so a beat with two
// results holds its entry until both go out. Reset (rst_n, async, low) empties the
// queue and clears the bit buffer and pending nibble; no clearing pass is needed.

module hamming74_stream_decoder_unit
    import hsd_pkg::*;
#(
    // entries in the front-to-back queue, two or more
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    hsd_in_if.sink    coded,
    hsd_out_if.source decoded
);

    // front to queue
    logic       push;
    hsd_entry_t push_entry;
    logic       q_full;

    // queue to back
    logic       head_valid;
    hsd_entry_t head_entry;
    logic       pop;

    // Front: shifts each coded beat into the bit buffer, corrects one or two
    // codewords and packs nibbles; a beat pushes if it ends a byte or is last.
    hsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .coded      (coded),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouples input stalls from output back pressure.
    hsd_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Back: one result beat per cycle from the head entry, while the sink is ready.
    hsd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .decoded    (decoded)
    );

endmodule

### rtl/core/hsd_front.sv
// Front end: gathers coded bits, corrects codewords and packs nibbles into entries.
`include "hamming74_stream_decoder_unit_macros.svh"

module hsd_front
    import hsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsd_in_if.sink     coded,
    input  logic       q_full,
    output logic       push,
    output hsd_entry_t push_entry
);

    logic [5:0] buf_reg, buf_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [3:0] pn_reg, pn_next;
    logic       pv_reg, pv_next;

    logic        accept;
    logic [13:0] wide;
    logic [3:0]  sh;
    logic [6:0]  word0;
    logic [3:0]  nib0;
    logic [3:0]  nib1;
    logic        two_words;
    logic [13:0] rem;

    assign coded.ready = !q_full;
    assign accept      = coded.valid && coded.ready;

    assign wide      = {buf_reg, coded.coded_byte};
    assign sh        = {1'b0, cnt_reg} + 4'd1;
    assign word0     = 7'(wide >> sh);
    assign nib0      = hsd_decode(word0);
    assign nib1      = hsd_decode(wide[6:0]);
    assign two_words = (cnt_reg == 3'd6);
    assign rem       = wide & ((14'd1 << sh) - 14'd1);

    always_comb
    begin
        logic [1:0] n;
        hsd_entry_t e;
        n        = 2'd0;
        e        = '0;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        pn_next  = pn_reg;
        pv_next  = pv_reg;
        if (accept)
        begin
            if (two_words)
            begin
                buf_next = 6'd0;
                cnt_next = 3'd0;
            end
            else
            begin
                buf_next = rem[5:0];
                cnt_next = sh[2:0];
            end
            // pair nibbles high first
            if (!two_words)
            begin
                if (pv_reg)
                begin
                    e.res0  = '{{pn_reg, nib0}, 2'd2, 1'b0};
                    n       = 2'd1;
                    pv_next = 1'b0;
                    pn_next = 4'd0;
                end
                else
                begin
                    pv_next = 1'b1;
                    pn_next = nib0;
                end
            end
            else
            begin
                n = 2'd1;
                if (pv_reg)
                begin
                    e.res0  = '{{pn_reg, nib0}, 2'd2, 1'b0};
                    pv_next = 1'b1;
                    pn_next = nib1;
                end
                else
                begin
                    e.res0  = '{{nib0, nib1}, 2'd2, 1'b0};
                    pv_next = 1'b0;
                    pn_next = 4'd0;
                end
            end
            if (coded.is_last)
            begin
                if (pv_next)
                begin
                    if (n == 2'd0)
                        e.res0 = '{{pn_next, 4'd0}, 2'd1, 1'b1};
                    else
                        e.res1 = '{{pn_next, 4'd0}, 2'd1, 1'b1};
                    n = n + 2'd1;
                end
                else if (n != 2'd0)
                    e.res0.end_of_message = 1'b1;
                else
                begin
                    e.res0 = '{8'd0, 2'd0, 1'b1};
                    n      = 2'd1;
                end
                buf_next = 6'd0;
                cnt_next = 3'd0;
                pn_next  = 4'd0;
                pv_next  = 1'b0;
            end
        end
        e.two      = (n == 2'd2);
        push       = accept && (n != 2'd0);
        push_entry = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= 6'd0;
            cnt_reg <= 3'd0;
            pn_reg  <= 4'd0;
            pv_reg  <= 1'b0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            pn_reg  <= pn_next;
            pv_reg  <= pv_next;
        end
    end

    `HSD_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && coded.is_last,
        cnt_reg == 3'd0 && !pv_reg && buf_reg == 6'd0)
    `HSD_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, cnt_reg <= 3'd6)

endmodule

### rtl/core/hsd_queue.sv
// Register queue of result entries between front and back ends.
`include "hamming74_stream_decoder_unit_macros.svh"

module hsd_queue
    import hsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hsd_entry_t push_entry,
    output logic       full,
    output logic       head_valid,
    output hsd_entry_t head_entry,
    input  logic       pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsd_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    `HSD_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `HSD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

### rtl/core/hsd_back.sv
// Back end: plays out the one or two results of the head entry, one beat each.
`include "hamming74_stream_decoder_unit_macros.svh"

module hsd_back
    import hsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  hsd_entry_t head_entry,
    output logic       pop,
    hsd_out_if.source  decoded
);

    logic        idx_reg, idx_next;
    logic        fire;
    hsd_result_t cur;

    assign cur   = idx_reg ? head_entry.res1 : head_entry.res0;
    assign fire  = decoded.valid && decoded.ready;
    assign pop   = fire && (idx_reg || !head_entry.two);

    assign decoded.valid          = head_valid;
    assign decoded.decoded_byte   = cur.decoded_byte;
    assign decoded.nibble_count   = cur.nibble_count;
    assign decoded.end_of_message = cur.end_of_message;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 1'b0;
        else
            idx_reg <= idx_next;
    end

    `HSD_ASSERT_NOW(a_second_only_when_two, clk, rst_n, head_valid && idx_reg,
        head_entry.two)

endmodule
